FILE: src/rtxt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtxt_pkg: shared types and constants for the radix text formatter
// Character codes, configuration register indexes and the state encoding
// of the digit engine.
// ----------------------------------------------------------------------------
package rtxt_pkg;

  // Characters that may never serve as digit symbols
  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;

  // Configuration data and radix widths
  localparam int CFG_DATA_W = 64;
  localparam int RADIX_W    = 5;

  // Dividend bits retired per cycle by the long division step
  localparam int STEP_BITS = 8;
  // Partial remainder trial width (remainder below 16, one extra bit, plus margin)
  localparam int TRIAL_W   = 6;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SYMBOLS_LOW  = 2'd0,
    CFG_SYMBOLS_HIGH = 2'd1,
    CFG_SYMBOL_COUNT = 2'd2
  } cfg_idx_e;

  // Digit engine states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_READ,
    ST_SEND
  } back_state_e;

endpackage

FILE: src/rtxt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtxt_if: channel interfaces of the radix text formatter
// Value input, character output and configuration write channels, each with
// a valid/ready handshake.
// ----------------------------------------------------------------------------

// Signed value requests
interface rtxt_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// Character results
interface rtxt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

// Register writes
interface rtxt_cfg_if;
  logic                              valid;
  logic                              ready;
  rtxt_pkg::cfg_idx_e                index;
  logic [rtxt_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/rtxt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtxt_front: configuration registers and request classification
// Holds the symbol table and radix, checks the table, and turns each valid
// request into a sign flag and magnitude for the digit engine queue.
// ----------------------------------------------------------------------------
module rtxt_front #(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rtxt_cfg_if.sink                          cfg_i,
  rtxt_in_if.sink                           in_i,
  output logic                              push_valid_o,
  input  logic                              push_ready_i,
  output logic [VALUE_BITS:0]               push_data_o,
  output logic [MAX_SYMBOLS-1:0][7:0]       sym_o,
  output logic [rtxt_pkg::RADIX_W-1:0]      radix_o
);

  localparam int LOW_N = (MAX_SYMBOLS < 8) ? MAX_SYMBOLS : 8;

  logic [MAX_SYMBOLS-1:0][7:0]         sym_q;
  logic [rtxt_pkg::RADIX_W-1:0]        radix_q;
  logic                                bad_sym;
  logic                                table_ok;
  logic                                neg;
  logic [VALUE_BITS-1:0]               raw;
  logic [VALUE_BITS-1:0]               mag;

  // Register writes; only the symbol bytes that can be in use are kept
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q   <= '0;
      radix_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rtxt_pkg::CFG_SYMBOLS_LOW: begin
          for (int n = 0; n < LOW_N; n++) begin
            sym_q[n] <= cfg_i.data[8*n +: 8];
          end
        end
        rtxt_pkg::CFG_SYMBOLS_HIGH: begin
          for (int n = 8; n < MAX_SYMBOLS; n++) begin
            sym_q[n] <= cfg_i.data[8*(n-8) +: 8];
          end
        end
        rtxt_pkg::CFG_SYMBOL_COUNT: begin
          radix_q <= cfg_i.data[rtxt_pkg::RADIX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Symbol table check: no sign characters, no duplicates among used symbols
  always_comb begin
    bad_sym = 1'b0;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (rtxt_pkg::RADIX_W'(i) < radix_q) begin
        if (sym_q[i] == rtxt_pkg::MINUS_CHAR || sym_q[i] == rtxt_pkg::PLUS_CHAR) begin
          bad_sym = 1'b1;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if (rtxt_pkg::RADIX_W'(j) < radix_q && sym_q[i] == sym_q[j]) begin
            bad_sym = 1'b1;
          end
        end
      end
    end
  end

  assign table_ok = !bad_sym && (radix_q >= rtxt_pkg::RADIX_W'(2)) &&
                    (radix_q <= rtxt_pkg::RADIX_W'(MAX_SYMBOLS));

  // Sign and magnitude; the most negative value maps onto its own bit pattern
  assign raw = in_i.value;
  assign neg = raw[VALUE_BITS-1];
  assign mag = neg ? (~raw + VALUE_BITS'(1)) : raw;

  // A request under a bad table is taken and dropped
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid && table_ok;
  assign push_data_o  = {neg, mag};

  assign sym_o   = sym_q;
  assign radix_o = radix_q;

endmodule

FILE: src/rtxt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtxt_fifo: two-entry queue between classifier and digit engine
// Lets the front take a new request while the engine is still busy.
// ----------------------------------------------------------------------------
module rtxt_fifo #(
  parameter int WIDTH = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

FILE: src/rtxt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtxt_back: digit engine
// Long division by the radix, eight dividend bits per cycle, pushes each
// remainder on a digit stack, then pops the stack into the output register
// behind an optional minus sign.
// ----------------------------------------------------------------------------
module rtxt_back #(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  logic [VALUE_BITS:0]           pop_data_i,
  input  logic [MAX_SYMBOLS-1:0][7:0]   sym_i,
  input  logic [rtxt_pkg::RADIX_W-1:0]  radix_i,
  rtxt_out_if.source                    out_o
);

  localparam int SYM_W  = $clog2(MAX_SYMBOLS);
  localparam int CHUNKS = (VALUE_BITS + rtxt_pkg::STEP_BITS - 1) / rtxt_pkg::STEP_BITS;
  localparam int PAD_W  = CHUNKS * rtxt_pkg::STEP_BITS;
  localparam int CH_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int PTR_W  = $clog2(VALUE_BITS);
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);

  rtxt_pkg::back_state_e state_q, state_d;

  logic [PAD_W-1:0]   work_q, work_d;
  logic [SYM_W-1:0]   rem_q, rem_d;
  logic [CH_W-1:0]    chunk_q, chunk_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               neg_q, neg_d;
  logic [SYM_W-1:0]   rd_q;
  logic [SYM_W-1:0]   stack_q [VALUE_BITS];
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_char_q, out_char_d;
  logic               out_last_q, out_last_d;

  logic [PAD_W-1:0]             div_work;
  logic [SYM_W-1:0]             div_rem;
  logic [rtxt_pkg::TRIAL_W-1:0] trial;
  logic                         last_chunk;
  logic                         div_done;
  logic                         load_ok;
  logic                         stack_we;
  logic                         rd_en;
  logic [PTR_W-1:0]             wr_addr;
  logic [PTR_W-1:0]             rd_addr;

  // One division step: eight restoring bits, quotient shifts in from the bottom
  always_comb begin
    div_work = work_q;
    div_rem  = rem_q;
    trial    = '0;
    for (int k = 0; k < rtxt_pkg::STEP_BITS; k++) begin
      trial    = rtxt_pkg::TRIAL_W'({div_rem, div_work[PAD_W-1]});
      div_work = {div_work[PAD_W-2:0], 1'b0};
      if (trial >= rtxt_pkg::TRIAL_W'(radix_i)) begin
        trial       = trial - rtxt_pkg::TRIAL_W'(radix_i);
        div_work[0] = 1'b1;
      end
      div_rem = trial[SYM_W-1:0];
    end
  end

  assign last_chunk = (chunk_q == CH_W'(CHUNKS - 1));
  assign div_done   = (div_work == '0) || (cnt_q == CNT_W'(VALUE_BITS - 1));
  assign load_ok    = !out_valid_q || out_o.ready;
  assign wr_addr    = cnt_q[PTR_W-1:0];
  assign rd_addr    = PTR_W'(cnt_q - CNT_W'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rtxt_pkg::ST_IDLE: begin
        if (pop_valid_i) begin
          state_d = rtxt_pkg::ST_DIVIDE;
        end
      end
      rtxt_pkg::ST_DIVIDE: begin
        if (last_chunk && div_done) begin
          state_d = neg_q ? rtxt_pkg::ST_SIGN : rtxt_pkg::ST_READ;
        end
      end
      rtxt_pkg::ST_SIGN: begin
        if (load_ok) begin
          state_d = rtxt_pkg::ST_READ;
        end
      end
      rtxt_pkg::ST_READ: begin
        state_d = rtxt_pkg::ST_SEND;
      end
      rtxt_pkg::ST_SEND: begin
        if (load_ok) begin
          state_d = (cnt_q == '0) ? rtxt_pkg::ST_IDLE : rtxt_pkg::ST_READ;
        end
      end
      default: begin
        state_d = rtxt_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and output register control
  always_comb begin
    work_d      = work_q;
    rem_d       = rem_q;
    chunk_d     = chunk_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    stack_we    = 1'b0;
    rd_en       = 1'b0;
    pop_ready_o = (state_q == rtxt_pkg::ST_IDLE);
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      rtxt_pkg::ST_IDLE: begin
        if (pop_valid_i) begin
          work_d  = PAD_W'(pop_data_i[VALUE_BITS-1:0]);
          neg_d   = pop_data_i[VALUE_BITS];
          rem_d   = '0;
          chunk_d = '0;
          cnt_d   = '0;
        end
      end
      rtxt_pkg::ST_DIVIDE: begin
        work_d = div_work;
        if (last_chunk) begin
          stack_we = 1'b1;
          cnt_d    = cnt_q + CNT_W'(1);
          rem_d    = '0;
          chunk_d  = '0;
        end else begin
          rem_d   = div_rem;
          chunk_d = chunk_q + CH_W'(1);
        end
      end
      rtxt_pkg::ST_SIGN: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          out_char_d  = rtxt_pkg::MINUS_CHAR;
          out_last_d  = 1'b0;
        end
      end
      rtxt_pkg::ST_READ: begin
        rd_en = 1'b1;
        cnt_d = cnt_q - CNT_W'(1);
      end
      rtxt_pkg::ST_SEND: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          out_char_d  = sym_i[rd_q];
          out_last_d  = (cnt_q == '0);
        end
      end
      default: begin
      end
    endcase
  end

  // Digit stack, registered read
  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_q[wr_addr] <= div_rem;
    end
    if (rd_en) begin
      rd_q <= stack_q[rd_addr];
    end
  end

  // Control and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtxt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      chunk_q     <= '0;
      work_q      <= '0;
      neg_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      chunk_q     <= chunk_d;
      work_q      <= work_d;
      neg_q       <= neg_d;
    end
  end

  // Remainder and output payload
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_char = out_char_q;
  assign out_o.last     = out_last_q;

endmodule

FILE: src/integer_to_radix_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_text: signed integer to text in a configurable radix
// Prints each value as characters, most significant digit first.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i  : register writes (symbols low, symbols high, symbol count); always
//            ready. Write only while no request is in flight.
//   in_i   : one signed value per request. A request is taken whenever the
//            two-entry queue has room; under a bad symbol table it is dropped.
//   out_o  : one character per result, last set on the final digit. A
//            negative value starts with '-'.
// Flow: the engine takes a request from the queue, then finds each digit by
//   long division over the whole dividend (eight dividend bits a cycle), then
//   sends the sign, if any, and each digit character by a stack read and an
//   output load. A queued request starts dividing while the last character
//   of the one before still waits in the output register.
// Reset: clears the control registers, the queue and the output valid flag;
//   the digit stack, remainder and output payload need no clearing. A
//   stalled receiver holds the output register and the engine waits,
//   while the queue keeps taking requests until full.
// ----------------------------------------------------------------------------
module integer_to_radix_text #(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtxt_cfg_if.sink    cfg_i,
  rtxt_in_if.sink     in_i,
  rtxt_out_if.source  out_o
);

  logic                                push_valid;
  logic                                push_ready;
  logic [VALUE_BITS:0]                 push_data;
  logic                                pop_valid;
  logic                                pop_ready;
  logic [VALUE_BITS:0]                 pop_data;
  logic [MAX_SYMBOLS-1:0][7:0]         sym;
  logic [rtxt_pkg::RADIX_W-1:0]        radix;

  // Register file and request classification
  rtxt_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data),
    .sym_o        (sym),
    .radix_o      (radix)
  );

  // Decoupling queue
  rtxt_fifo #(
    .WIDTH (VALUE_BITS + 1)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Digit engine and output register
  rtxt_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .sym_i       (sym),
    .radix_i     (radix),
    .out_o       (out_o)
  );

endmodule

FILE: tb/rtxt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtxt_checker: result checker for the radix text formatter
// Watches the configuration, value and character channels, keeps its own
// copy of the symbol table, works out the text for every accepted value
// request and compares each accepted character against it.
// ----------------------------------------------------------------------------
module rtxt_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration channel
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  rtxt_pkg::cfg_idx_e              cfg_index_i,
  input  logic [rtxt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // value channel
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [31:0]                     in_value_i,
  // character channel
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [7:0]                      out_char_i,
  input  logic                            out_last_i,
  // status to the top
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);

  localparam int VALUE_BITS  = 32;
  localparam int MAX_SYMBOLS = 16;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  // Mirror of the configuration registers
  logic [rtxt_pkg::CFG_DATA_W-1:0] sym_lo;
  logic [rtxt_pkg::CFG_DATA_W-1:0] sym_hi;
  logic [rtxt_pkg::RADIX_W-1:0]    sym_count;

  // Characters still owed by the block, oldest first
  text_char_t text_q[$];
  text_char_t want;

  function automatic logic [7:0] symbol_of(input int unsigned d);
    return (d < 8) ? sym_lo[8*d +: 8] : sym_hi[8*(d-8) +: 8];
  endfunction

  // Table is usable when it has 2..16 distinct symbols and no sign character
  function automatic bit table_usable();
    int cnt;
    cnt = int'(sym_count);
    if (cnt < 2 || cnt > MAX_SYMBOLS) return 1'b0;
    for (int i = 0; i < cnt; i++) begin
      if (symbol_of(i) == rtxt_pkg::MINUS_CHAR || symbol_of(i) == rtxt_pkg::PLUS_CHAR)
        return 1'b0;
      for (int j = i + 1; j < cnt; j++) begin
        if (symbol_of(j) == symbol_of(i)) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Digits by repeated division, then sign and digits most significant first
  function automatic void format_value(input logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] radix;
    logic [3:0]            digits [VALUE_BITS];
    int                    n;
    if (!table_usable()) return;
    radix = VALUE_BITS'(sym_count);
    // two's complement negate; the most negative value maps onto itself
    mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    n = 0;
    do begin
      digits[n] = 4'(mag % radix);
      mag       = mag / radix;
      n++;
    end while (mag != 0 && n < VALUE_BITS);
    if (v[VALUE_BITS-1])
      text_q.push_back(text_char_t'{ch: rtxt_pkg::MINUS_CHAR, last: 1'b0});
    for (int i = n - 1; i >= 0; i--) begin
      text_q.push_back(text_char_t'{ch: symbol_of(digits[i]), last: (i == 0)});
    end
  endfunction

  // Track requests and check results at every edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_lo       = '0;
      sym_hi       = '0;
      sym_count    = '0;
      fail_count_o = 0;
      text_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          rtxt_pkg::CFG_SYMBOLS_LOW:  sym_lo = cfg_data_i;
          rtxt_pkg::CFG_SYMBOLS_HIGH: sym_hi = cfg_data_i;
          rtxt_pkg::CFG_SYMBOL_COUNT: sym_count = cfg_data_i[rtxt_pkg::RADIX_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) format_value(in_value_i);

      if (out_valid_i && out_ready_i) begin
        if (text_q.size() == 0) begin
          if (fail_count_o < REPORT_MAX)
            $display("%0t: unexpected char %02h last %0b", $realtime, out_char_i, out_last_i);
          fail_count_o++;
        end else begin
          want = text_q.pop_front();
          if (want.ch !== out_char_i || want.last !== out_last_i) begin
            if (fail_count_o < REPORT_MAX)
              $display("%0t: char expected %02h last %0b, got %02h last %0b", $realtime,
                       want.ch, want.last, out_char_i, out_last_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = text_q.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the radix text formatter
// Loads symbol tables while the block is idle, sends directed corner values
// and then random values in bursts, with a receiver that stalls on changing
// patterns and once for a long stretch. Checking is done by rtxt_checker.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          RANDOM_ITEMS     = 150;
  localparam int          SETTLE_CYCLES    = 100;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam longint      TIMEOUT_NS       = 5_000_000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Long receiver hold is requested by flipping this bit
  logic hold_flip = 1'b0;

  int unsigned fail_count;
  int unsigned pending;

  int burst_left = 0;
  bit gapless    = 1'b0;

  rtxt_cfg_if             cfg_ch ();
  rtxt_in_if #(.VALUE_BITS(32)) in_ch ();
  rtxt_out_if             out_ch ();

  integer_to_radix_text #(
    .MAX_SYMBOLS(16),
    .VALUE_BITS (32)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_ch),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  rtxt_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_ch.valid),
    .cfg_ready_i (cfg_ch.ready),
    .cfg_index_i (cfg_ch.index),
    .cfg_data_i  (cfg_ch.data),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_value_i  (in_ch.value),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_char_i  (out_ch.out_char),
    .out_last_i  (out_ch.last),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop
  initial begin
    #(TIMEOUT_NS);
    $display("integer_to_radix_text: mismatch");
    $finish;
  end

  task automatic write_reg(input rtxt_pkg::cfg_idx_e idx, input logic [63:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // All three registers, in cyclic order from a random first one
  task automatic load_table(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [63:0] cnt);
    int first;
    first = $urandom_range(0, 2);
    for (int k = 0; k < 3; k++) begin
      case ((first + k) % 3)
        0:       write_reg(rtxt_pkg::CFG_SYMBOLS_LOW, lo);
        1:       write_reg(rtxt_pkg::CFG_SYMBOLS_HIGH, hi);
        default: write_reg(rtxt_pkg::CFG_SYMBOL_COUNT, cnt);
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // One value request; a gap may open before a new burst
  task automatic send_value(input logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = gapless ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop sending, wait for every owed character, then let the engine go idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: stall patterns that change every so often, plus one long hold
  initial begin
    int       mode;
    int       mode_left;
    logic     hold_seen;
    logic [7:0] pat;
    mode      = 0;
    mode_left = 0;
    hold_seen = 1'b0;
    pat       = 8'h01;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_flip != hold_seen) begin
        hold_seen = hold_flip;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 256);
        pat       = 8'($urandom_range(1, 255));
      end
      mode_left--;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: begin
          out_ch.ready <= pat[0];
          pat = {pat[0], pat[7:1]};
        end
      endcase
    end
  end

  // Stimulus
  initial begin
    logic [7:0]  sym [16];
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] cnt_data;
    logic [31:0] v;
    int          radix;
    int          count_val;
    int          n_items;
    int          random_sent;
    int          pos;
    int          other;
    bit          table_bad;
    bit          hold_done;
    bit          clash;

    random_sent = 0;
    hold_done   = 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= rtxt_pkg::CFG_SYMBOLS_LOW;
    cfg_ch.data  <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset table has no symbols: request is dropped
    send_value(32'd7);
    settle();

    // Decimal, corner values
    load_table(64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938, 64'd10);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd10);
    send_value(32'hFFFF_FFF6);
    send_value(32'd9);
    settle();

    // Binary with 0x00 and 0xFF symbols; sign characters sit in unused bytes
    load_table(64'h2B2D_2B2D_2B2D_FF00, 64'h2D2B_2D2B_2D2B_2D2B, 64'd2);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'd0);
    send_value(32'd5);
    settle();

    // Hex; count written with its unused upper data bits set
    load_table(64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, 64'hFFFF_FFFF_FFFF_FFF0);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    settle();

    // Rejected tables: one symbol, more than sixteen, all 0xFF, plus, minus, repeat
    load_table(64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, 64'd1);
    send_value(32'd3);
    settle();
    load_table(64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, 64'd17);
    send_value(32'd3);
    settle();
    load_table(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_value(32'd3);
    settle();
    load_table(64'h3736_2B34_3332_3130, 64'h0000_0000_0000_3938, 64'd10);
    send_value(32'd3);
    settle();
    load_table(64'h3736_3534_3332_3130, 64'h0000_0000_0000_2D38, 64'd10);
    send_value(32'd3);
    settle();
    load_table(64'h3036_3534_3332_3130, 64'h0000_0000_0000_3938, 64'd10);
    send_value(32'd3);
    settle();

    // Random tables and values
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       radix = 10;
        1:       radix = 2;
        2:       radix = 16;
        default: radix = $urandom_range(2, 16);
      endcase
      for (int i = 0; i < 16; i++) sym[i] = 8'($urandom_range(0, 255));
      // distinct, sign-free symbols for the digits in use
      for (int i = 0; i < radix; i++) begin
        do begin
          sym[i] = 8'($urandom_range(0, 255));
          clash  = (sym[i] == rtxt_pkg::MINUS_CHAR) || (sym[i] == rtxt_pkg::PLUS_CHAR);
          for (int j = 0; j < i; j++) if (sym[j] == sym[i]) clash = 1'b1;
        end while (clash);
      end
      count_val = radix;
      table_bad = ($urandom_range(0, 6) == 0);
      if (table_bad) begin
        pos = $urandom_range(0, radix - 1);
        case ($urandom_range(0, 4))
          0: count_val = $urandom_range(0, 1);
          1: count_val = $urandom_range(17, 31);
          2: sym[pos] = rtxt_pkg::PLUS_CHAR;
          3: sym[pos] = rtxt_pkg::MINUS_CHAR;
          default: begin
            other = (pos + $urandom_range(1, radix - 1)) % radix;
            sym[other] = sym[pos];
          end
        endcase
      end
      for (int b = 0; b < 8; b++) begin
        lo[8*b +: 8] = sym[b];
        hi[8*b +: 8] = sym[8+b];
      end
      cnt_data = 64'(count_val);
      if ($urandom_range(0, 3) == 0)
        cnt_data = ({$urandom(), $urandom()} & ~64'h1F) | 64'(count_val);
      load_table(lo, hi, cnt_data);

      gapless = ($urandom_range(0, 3) == 0);
      n_items = table_bad ? 3 : $urandom_range(4, 14);
      if (!table_bad && !hold_done) begin
        // receiver holds off while requests keep coming, filling the queue
        hold_done = 1'b1;
        gapless   = 1'b1;
        n_items   = 14;
        hold_flip <= ~hold_flip;
      end

      for (int k = 0; k < n_items; k++) begin
        case ($urandom_range(0, 7))
          0: v = $urandom_range(0, 40);
          1: v = 32'd0 - $urandom_range(1, 40);
          2: begin
            case ($urandom_range(0, 3))
              0:       v = 32'h8000_0000;
              1:       v = 32'h7FFF_FFFF;
              2:       v = 32'd0;
              default: v = 32'hFFFF_FFFF;
            endcase
          end
          3: begin
            v = $urandom() >> $urandom_range(0, 31);
            if ($urandom_range(0, 1)) v = 32'd0 - v;
          end
          default: v = $urandom();
        endcase
        send_value(v);
        if (!table_bad) random_sent++;
        if ($urandom_range(0, 19) == 0) settle();
      end
      settle();
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("integer_to_radix_text: match");
    end else begin
      $display("integer_to_radix_text: mismatch");
    end
    $finish;
  end

endmodule

FILE: integer_to_radix_text.f
src/rtxt_pkg.sv
src/rtxt_if.sv
src/rtxt_front.sv
src/rtxt_fifo.sv
src/rtxt_back.sv
src/integer_to_radix_text.sv
tb/rtxt_checker.sv
tb/testbench.sv
